>>> sv/env_scg_pkg.sv
// Shared constants, register map and shift helpers for the sensor compensation gate.
package env_scg_pkg;

    // Configuration register map (index = paddr[5:3])
    typedef enum logic [2:0] {
        REG_CAL_TEMP      = 3'd0,
        REG_CAL_PRESS_LO  = 3'd1,
        REG_CAL_PRESS_HI  = 3'd2,
        REG_CAL_MISC      = 3'd3,
        REG_CAL_HUM       = 3'd4,
        REG_TEMP_FLOOR    = 3'd5,
        REG_TEMP_CEILING  = 3'd6,
        REG_TEMP_MAX_STEP = 3'd7
    } reg_idx_t;

    localparam logic [15:0] TEMP_FLOOR_RST    = 16'hF060;  // -4000
    localparam logic [15:0] TEMP_CEILING_RST  = 16'd8500;
    localparam logic [15:0] TEMP_MAX_STEP_RST = 16'd200;

    localparam logic [26:0] TEMP_RND    = 27'd128;
    localparam logic [63:0] PRESS_T_OFS = 64'd128000;
    localparam logic [63:0] PRESS_ONE   = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] PRESS_BIAS  = 64'h0000_8000_0000_0000;  // 2^47
    localparam logic [31:0] HUM_T_OFS   = 32'd76800;
    localparam logic [31:0] HUM_FULL    = 32'd419430400;
    localparam logic [31:0] HUM_OFS_B   = 32'd2097152;
    localparam logic [31:0] HUM_RND     = 32'd16384;
    localparam logic [31:0] HUM_HALF    = 32'd32768;
    localparam logic [31:0] HUM_RND2    = 32'd8192;

    function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] s);
        logic signed [63:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

endpackage

>>> sv/env_sensor_compensation_gate.sv
// Top level: sensor compensation gate with plausibility check and reject counting.
// Sequencing: every multiply runs on the shared 64-bit multiplier; a rejected reading
//   stops after the temperature check, an accepted one runs up to 21 multiplies and a divide.
// Throughput: one reading at a time; s_tready is high only between readings, set by the
//   multiply/divide sequencer. A finished beat waits in the output register.
// Reset: synchronous active-low aresetn; calibration cleared, limits to defaults, state zeroed.
module env_sensor_compensation_gate (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    input  logic         s_tuser,   // is_retry
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // temp_centi[15:0], press_q24_8[47:16], press_pa[71:48],
                                    // hum_centi[85:72], reject_total[117:86], zero pad
    output logic         m_tuser,   // accepted
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    // One-hot sequencer: temperature, check, pressure, humidity, finish.
    typedef enum logic [28:0] {
        ST_IDLE   = 29'd1 << 0,
        ST_T_V1   = 29'd1 << 1,
        ST_T_SQ   = 29'd1 << 2,
        ST_T_V2   = 29'd1 << 3,
        ST_T_FIN  = 29'd1 << 4,
        ST_T_CHK  = 29'd1 << 5,
        ST_P_AA   = 29'd1 << 6,
        ST_P_B1   = 29'd1 << 7,
        ST_P_B2   = 29'd1 << 8,
        ST_P_C1   = 29'd1 << 9,
        ST_P_C2   = 29'd1 << 10,
        ST_P_A    = 29'd1 << 11,
        ST_P_NUM  = 29'd1 << 12,
        ST_P_DIV  = 29'd1 << 13,
        ST_P_SQ   = 29'd1 << 14,
        ST_P_A2   = 29'd1 << 15,
        ST_P_B3   = 29'd1 << 16,
        ST_P_SUM  = 29'd1 << 17,
        ST_P_SUM2 = 29'd1 << 18,
        ST_P_OUT  = 29'd1 << 19,
        ST_H_A    = 29'd1 << 20,
        ST_H_T1   = 29'd1 << 21,
        ST_H_T2   = 29'd1 << 22,
        ST_H_B1   = 29'd1 << 23,
        ST_H_B2   = 29'd1 << 24,
        ST_H_V    = 29'd1 << 25,
        ST_H_Y    = 29'd1 << 26,
        ST_H_FIN  = 29'd1 << 27,
        ST_FINISH = 29'd1 << 28
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_lo_reg;
    logic [63:0] cal_press_hi_reg;
    logic [39:0] cal_misc_reg;
    logic [47:0] cal_hum_reg;
    logic [15:0] temp_floor_reg;
    logic [15:0] temp_ceiling_reg;
    logic [15:0] temp_max_step_reg;

    // captured beat
    logic [19:0] rt_reg;
    logic [19:0] rp_reg;
    logic [15:0] rh_reg;
    logic        retry_reg;

    // working registers
    logic [63:0]        ra_reg;
    logic [63:0]        rb_reg;
    logic [63:0]        rc_reg;
    logic [63:0]        aa_reg;
    logic [63:0]        p_reg;
    logic signed [23:0] tfine_reg;
    logic signed [17:0] temp_reg;
    logic               ok_reg;
    logic [31:0]        pq_reg;
    logic [16:0]        hq_reg;

    // persistent state
    logic signed [15:0] last_temp_reg;
    logic               have_last_reg;
    logic [31:0]        reject_cnt_reg;

    // output register
    logic         m_tvalid_reg;
    logic [119:0] m_tdata_reg;
    logic         m_tuser_reg;

    // shared units
    logic        unit_wait_reg;
    logic        use_mul;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] mul_prod;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_quot;

    // coefficient fields; p1, h1 and h3 zero-extended to 64, the other 64-bit ones sign-extended
    logic [15:0] t1;
    logic [63:0] t2_64, t3_64;
    logic [63:0] p1_64, p2_64, p3_64, p4_64, p5_64, p6_64, p8_64, p9_64;
    logic [15:0] p7;
    logic [63:0] h1_64, h2_64, h3_64, h5_64, h6_64;
    logic [15:0] h4;

    assign t1    = cal_temp_reg[15:0];
    assign t2_64 = {{48{cal_temp_reg[31]}}, cal_temp_reg[31:16]};
    assign t3_64 = {{48{cal_temp_reg[47]}}, cal_temp_reg[47:32]};
    assign p1_64 = {48'd0, cal_press_lo_reg[15:0]};
    assign p2_64 = {{48{cal_press_lo_reg[31]}}, cal_press_lo_reg[31:16]};
    assign p3_64 = {{48{cal_press_lo_reg[47]}}, cal_press_lo_reg[47:32]};
    assign p4_64 = {{48{cal_press_lo_reg[63]}}, cal_press_lo_reg[63:48]};
    assign p5_64 = {{48{cal_press_hi_reg[15]}}, cal_press_hi_reg[15:0]};
    assign p6_64 = {{48{cal_press_hi_reg[31]}}, cal_press_hi_reg[31:16]};
    assign p7    = cal_press_hi_reg[47:32];
    assign p8_64 = {{48{cal_press_hi_reg[63]}}, cal_press_hi_reg[63:48]};
    assign p9_64 = {{48{cal_misc_reg[15]}}, cal_misc_reg[15:0]};
    assign h1_64 = {56'd0, cal_misc_reg[23:16]};
    assign h3_64 = {56'd0, cal_misc_reg[31:24]};
    assign h6_64 = {{56{cal_misc_reg[39]}}, cal_misc_reg[39:32]};
    assign h2_64 = {{48{cal_hum_reg[15]}}, cal_hum_reg[15:0]};
    assign h4    = cal_hum_reg[31:16];
    assign h5_64 = {{48{cal_hum_reg[47]}}, cal_hum_reg[47:32]};

    // temperature operands
    logic [63:0] d1, d2;
    assign d1 = {47'd0, rt_reg[19:3]} - {47'd0, t1, 1'b0};
    assign d2 = {48'd0, rt_reg[19:4]} - {48'd0, t1};

    logic [63:0] sh11, sh12, sh14;
    assign sh11 = env_scg_pkg::asr64(mul_prod, 6'd11);
    assign sh12 = env_scg_pkg::asr64(mul_prod, 6'd12);
    assign sh14 = env_scg_pkg::asr64(mul_prod, 6'd14);

    // temp = (t_fine * 5 + 128) >>> 8
    logic [26:0] tf27, ts27;
    assign tf27 = {{3{tfine_reg[23]}}, tfine_reg};
    assign ts27 = (tf27 << 2) + tf27 + env_scg_pkg::TEMP_RND;

    // plausibility check
    logic signed [17:0] floor18, ceil18;
    logic signed [18:0] diff19;
    logic [18:0]        absd;
    logic               ok_w;
    assign floor18 = {{2{temp_floor_reg[15]}}, temp_floor_reg};
    assign ceil18  = {{2{temp_ceiling_reg[15]}}, temp_ceiling_reg};
    assign diff19  = {temp_reg[17], temp_reg} - {{3{last_temp_reg[15]}}, last_temp_reg};
    assign absd    = diff19[18] ? 19'd0 - diff19 : diff19;
    assign ok_w    = (temp_reg >= floor18) && (temp_reg <= ceil18) &&
                     (!have_last_reg || (absd <= {3'd0, temp_max_step_reg}));

    // pressure helpers
    logic [63:0] pa0, pdiff, pnum_op, psq_op;
    logic [31:0] pq_w;
    assign pa0     = {{40{tfine_reg[23]}}, tfine_reg} - env_scg_pkg::PRESS_T_OFS;
    assign pdiff   = env_scg_pkg::PRESS_ONE - {44'd0, rp_reg};
    assign pnum_op = (pdiff << 31) - rb_reg;
    assign psq_op  = env_scg_pkg::asr64(p_reg, 6'd13);
    assign pq_w    = p_reg[39:8] + {{12{p7[15]}}, p7, 4'd0};

    // humidity helpers (32-bit wrap)
    logic [31:0] vh, m32, ha_sum, ha_w, sh10, hw, hv, hcl;
    logic [16:0] hq_w;
    assign vh     = {{8{tfine_reg[23]}}, tfine_reg} - env_scg_pkg::HUM_T_OFS;
    assign m32    = mul_prod[31:0];
    assign ha_sum = {2'd0, rh_reg, 14'd0} - {h4[11:0], 20'd0} - m32 + env_scg_pkg::HUM_RND;
    assign ha_w   = env_scg_pkg::asr32(ha_sum, 5'd15);
    assign sh10   = env_scg_pkg::asr32(m32, 5'd10);
    assign hw     = env_scg_pkg::asr32(rc_reg[31:0], 5'd15);
    assign hv     = rc_reg[31:0] - env_scg_pkg::asr32(m32, 5'd4);
    // clamp to 0..100 %RH
    assign hcl    = hv[31] ? 32'd0 :
                    ((hv > env_scg_pkg::HUM_FULL) ? env_scg_pkg::HUM_FULL : hv);
    assign hq_w   = hcl[28:12];

    // result formatting
    logic [15:0] temp_sat;
    logic [23:0] hq100;
    assign temp_sat = (temp_reg > 18'sd32767)  ? 16'h7FFF :
                      (temp_reg < -18'sd32768) ? 16'h8000 : temp_reg[15:0];
    assign hq100    = ({7'd0, hq_reg} << 6) + ({7'd0, hq_reg} << 5) + ({7'd0, hq_reg} << 2);

    // multiplier operand select per sequencer step
    always_comb begin
        use_mul = 1'b0;
        mul_a   = 64'd0;
        mul_b   = 64'd0;
        case (state_reg)
            ST_T_V1:  begin use_mul = 1'b1; mul_a = d1;     mul_b = t2_64; end
            ST_T_SQ:  begin use_mul = 1'b1; mul_a = d2;     mul_b = d2;    end
            ST_T_V2:  begin use_mul = 1'b1; mul_a = rc_reg; mul_b = t3_64; end
            ST_P_AA:  begin use_mul = 1'b1; mul_a = pa0;    mul_b = pa0;   end
            ST_P_B1:  begin use_mul = 1'b1; mul_a = aa_reg; mul_b = p6_64; end
            ST_P_B2:  begin use_mul = 1'b1; mul_a = pa0;    mul_b = p5_64; end
            ST_P_C1:  begin use_mul = 1'b1; mul_a = aa_reg; mul_b = p3_64; end
            ST_P_C2:  begin use_mul = 1'b1; mul_a = pa0;    mul_b = p2_64; end
            ST_P_A: begin
                use_mul = 1'b1;
                mul_a   = env_scg_pkg::PRESS_BIAS + rc_reg;
                mul_b   = p1_64;
            end
            ST_P_NUM: begin
                use_mul = (ra_reg != 64'd0);
                mul_a   = pnum_op;
                mul_b   = env_scg_pkg::PRESS_SCALE;
            end
            ST_P_SQ:  begin use_mul = 1'b1; mul_a = psq_op; mul_b = psq_op; end
            ST_P_A2:  begin use_mul = 1'b1; mul_a = p9_64;  mul_b = rc_reg; end
            ST_P_B3:  begin use_mul = 1'b1; mul_a = p8_64;  mul_b = p_reg;  end
            ST_H_A:   begin use_mul = 1'b1; mul_a = h5_64;  mul_b = {32'd0, vh}; end
            ST_H_T1:  begin use_mul = 1'b1; mul_a = h6_64;  mul_b = {32'd0, vh}; end
            ST_H_T2:  begin use_mul = 1'b1; mul_a = h3_64;  mul_b = {32'd0, vh}; end
            ST_H_B1:  begin use_mul = 1'b1; mul_a = rb_reg; mul_b = rc_reg; end
            ST_H_B2:  begin use_mul = 1'b1; mul_a = rb_reg; mul_b = h2_64;  end
            ST_H_V:   begin use_mul = 1'b1; mul_a = ra_reg; mul_b = rb_reg; end
            ST_H_Y:   begin use_mul = 1'b1; mul_a = {32'd0, hw}; mul_b = {32'd0, hw}; end
            ST_H_FIN: begin use_mul = 1'b1; mul_a = rb_reg; mul_b = h1_64;  end
            default:  ;
        endcase
    end

    assign mul_start = use_mul && !unit_wait_reg;
    assign div_start = (state_reg == ST_P_DIV) && !unit_wait_reg;

    env_scg_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    env_scg_div64 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rc_reg),
        .divisor  (ra_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // config write / read
    logic                  cfg_we;
    env_scg_pkg::reg_idx_t cfg_idx;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = env_scg_pkg::reg_idx_t'(paddr[5:3]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg      <= 48'd0;
            cal_press_lo_reg  <= 64'd0;
            cal_press_hi_reg  <= 64'd0;
            cal_misc_reg      <= 40'd0;
            cal_hum_reg       <= 48'd0;
            temp_floor_reg    <= env_scg_pkg::TEMP_FLOOR_RST;
            temp_ceiling_reg  <= env_scg_pkg::TEMP_CEILING_RST;
            temp_max_step_reg <= env_scg_pkg::TEMP_MAX_STEP_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                env_scg_pkg::REG_CAL_TEMP:      cal_temp_reg      <= pwdata[47:0];
                env_scg_pkg::REG_CAL_PRESS_LO:  cal_press_lo_reg  <= pwdata;
                env_scg_pkg::REG_CAL_PRESS_HI:  cal_press_hi_reg  <= pwdata;
                env_scg_pkg::REG_CAL_MISC:      cal_misc_reg      <= pwdata[39:0];
                env_scg_pkg::REG_CAL_HUM:       cal_hum_reg       <= pwdata[47:0];
                env_scg_pkg::REG_TEMP_FLOOR:    temp_floor_reg    <= pwdata[15:0];
                env_scg_pkg::REG_TEMP_CEILING:  temp_ceiling_reg  <= pwdata[15:0];
                env_scg_pkg::REG_TEMP_MAX_STEP: temp_max_step_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            env_scg_pkg::REG_CAL_TEMP:      prdata = {16'd0, cal_temp_reg};
            env_scg_pkg::REG_CAL_PRESS_LO:  prdata = cal_press_lo_reg;
            env_scg_pkg::REG_CAL_PRESS_HI:  prdata = cal_press_hi_reg;
            env_scg_pkg::REG_CAL_MISC:      prdata = {24'd0, cal_misc_reg};
            env_scg_pkg::REG_CAL_HUM:       prdata = {16'd0, cal_hum_reg};
            env_scg_pkg::REG_TEMP_FLOOR:    prdata = {48'd0, temp_floor_reg};
            env_scg_pkg::REG_TEMP_CEILING:  prdata = {48'd0, temp_ceiling_reg};
            env_scg_pkg::REG_TEMP_MAX_STEP: prdata = {48'd0, temp_max_step_reg};
            default:                        prdata = 64'd0;
        endcase
    end

    // control: sequencer, unit handshake, persistent state, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            unit_wait_reg  <= 1'b0;
            last_temp_reg  <= 16'sd0;
            have_last_reg  <= 1'b0;
            reject_cnt_reg <= 32'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (mul_start || div_start) begin
                unit_wait_reg <= 1'b1;
            end else if (mul_done || div_done) begin
                unit_wait_reg <= 1'b0;
            end

            if ((state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:   if (s_tvalid) state_reg <= ST_T_V1;
                ST_T_V1:   if (mul_done) state_reg <= ST_T_SQ;
                ST_T_SQ:   if (mul_done) state_reg <= ST_T_V2;
                ST_T_V2:   if (mul_done) state_reg <= ST_T_FIN;
                ST_T_FIN:  state_reg <= ST_T_CHK;
                ST_T_CHK: begin
                    if (ok_w) begin
                        last_temp_reg <= temp_reg[15:0];
                        have_last_reg <= 1'b1;
                        state_reg     <= ST_P_AA;
                    end else begin
                        if (retry_reg) begin
                            reject_cnt_reg <= reject_cnt_reg + 32'd1;
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_P_AA:   if (mul_done) state_reg <= ST_P_B1;
                ST_P_B1:   if (mul_done) state_reg <= ST_P_B2;
                ST_P_B2:   if (mul_done) state_reg <= ST_P_C1;
                ST_P_C1:   if (mul_done) state_reg <= ST_P_C2;
                ST_P_C2:   if (mul_done) state_reg <= ST_P_A;
                ST_P_A:    if (mul_done) state_reg <= ST_P_NUM;
                ST_P_NUM: begin
                    // zero divisor: pressure stays zero, go on to humidity
                    if (ra_reg == 64'd0) begin
                        state_reg <= ST_H_A;
                    end else if (mul_done) begin
                        state_reg <= ST_P_DIV;
                    end
                end
                ST_P_DIV:  if (div_done) state_reg <= ST_P_SQ;
                ST_P_SQ:   if (mul_done) state_reg <= ST_P_A2;
                ST_P_A2:   if (mul_done) state_reg <= ST_P_B3;
                ST_P_B3:   if (mul_done) state_reg <= ST_P_SUM;
                ST_P_SUM:  state_reg <= ST_P_SUM2;
                ST_P_SUM2: state_reg <= ST_P_OUT;
                ST_P_OUT:  state_reg <= ST_H_A;
                ST_H_A:    if (mul_done) state_reg <= ST_H_T1;
                ST_H_T1:   if (mul_done) state_reg <= ST_H_T2;
                ST_H_T2:   if (mul_done) state_reg <= ST_H_B1;
                ST_H_B1:   if (mul_done) state_reg <= ST_H_B2;
                ST_H_B2:   if (mul_done) state_reg <= ST_H_V;
                ST_H_V:    if (mul_done) state_reg <= ST_H_Y;
                ST_H_Y:    if (mul_done) state_reg <= ST_H_FIN;
                ST_H_FIN:  if (mul_done) state_reg <= ST_FINISH;
                ST_FINISH: if (!m_tvalid_reg || m_tready) state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rt_reg    <= s_tdata[19:0];
                    rp_reg    <= s_tdata[39:20];
                    rh_reg    <= s_tdata[55:40];
                    retry_reg <= s_tuser;
                end
            end
            ST_T_V1:  if (mul_done) tfine_reg <= sh11[23:0];
            ST_T_SQ:  if (mul_done) rc_reg <= sh12;
            ST_T_V2:  if (mul_done) tfine_reg <= tfine_reg + sh14[23:0];
            ST_T_FIN: temp_reg <= ts27[25:8];
            ST_T_CHK: begin
                ok_reg <= ok_w;
                pq_reg <= 32'd0;
                hq_reg <= 17'd0;
            end
            ST_P_AA:  if (mul_done) aa_reg <= mul_prod;
            ST_P_B1:  if (mul_done) rb_reg <= mul_prod + (p4_64 << 35);
            ST_P_B2:  if (mul_done) rb_reg <= rb_reg + (mul_prod << 17);
            ST_P_C1:  if (mul_done) rc_reg <= env_scg_pkg::asr64(mul_prod, 6'd8);
            ST_P_C2:  if (mul_done) rc_reg <= rc_reg + (mul_prod << 12);
            ST_P_A:   if (mul_done) ra_reg <= env_scg_pkg::asr64(mul_prod, 6'd33);
            ST_P_NUM: if (mul_done) rc_reg <= mul_prod;
            ST_P_DIV: if (div_done) p_reg <= div_quot;
            ST_P_SQ:  if (mul_done) rc_reg <= mul_prod;
            ST_P_A2:  if (mul_done) ra_reg <= env_scg_pkg::asr64(mul_prod, 6'd25);
            ST_P_B3:  if (mul_done) rb_reg <= env_scg_pkg::asr64(mul_prod, 6'd19);
            ST_P_SUM:  p_reg  <= p_reg + ra_reg;
            ST_P_SUM2: p_reg  <= p_reg + rb_reg;
            ST_P_OUT:  pq_reg <= pq_w;
            ST_H_A:   if (mul_done) ra_reg <= {32'd0, ha_w};
            ST_H_T1:  if (mul_done) rb_reg <= {32'd0, sh10};
            ST_H_T2: begin
                if (mul_done) begin
                    rc_reg <= {32'd0, env_scg_pkg::asr32(m32, 5'd11) + env_scg_pkg::HUM_HALF};
                end
            end
            ST_H_B1:  if (mul_done) rb_reg <= {32'd0, sh10 + env_scg_pkg::HUM_OFS_B};
            ST_H_B2: begin
                if (mul_done) begin
                    rb_reg <= {32'd0, env_scg_pkg::asr32(m32 + env_scg_pkg::HUM_RND2, 5'd14)};
                end
            end
            ST_H_V:   if (mul_done) rc_reg <= {32'd0, m32};
            ST_H_Y:   if (mul_done) rb_reg <= {32'd0, env_scg_pkg::asr32(m32, 5'd7)};
            ST_H_FIN: if (mul_done) hq_reg <= hq_w;
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tuser_reg <= ok_reg;
                    m_tdata_reg <= {2'd0, reject_cnt_reg, hq100[23:10], pq_reg[31:8],
                                    pq_reg, temp_sat};
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_P_DIV) |-> (ra_reg != 64'd0))
        else $error("divider entered with zero divisor");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_T_V1))
        else $error("accepted beat did not start the sequence");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_done || div_done) |-> unit_wait_reg)
        else $error("unit finished without a pending request");

    a_reject_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (reject_cnt_reg != $past(reject_cnt_reg)) |->
        (reject_cnt_reg == $past(reject_cnt_reg) + 32'd1))
        else $error("reject counter moved by more than one");
`endif

endmodule

>>> sv/env_scg_mul64.sv
// 64x64 wrapping multiplier built from one 32x32 multiplier that forms the partial products in turn.
module env_scg_mul64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] prod
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [1:0]  ph_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx;
    logic [31:0] my;

    // partial products: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
    always_comb begin
        case (ph_reg)
            2'd0: begin
                mx = a_reg[31:0];
                my = b_reg[31:0];
            end
            2'd1: begin
                mx = a_reg[31:0];
                my = b_reg[63:32];
            end
            default: begin
                mx = a_reg[63:32];
                my = b_reg[31:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= 2'd0;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 2'd1;
                if (ph_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (busy_reg) begin
            pp_reg <= {32'd0, mx} * {32'd0, my};
            case (ph_reg)
                2'd1:    acc_reg <= pp_reg;
                2'd2,
                2'd3:    acc_reg[63:32] <= acc_reg[63:32] + pp_reg[31:0];
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> sv/env_scg_div64.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncates toward zero.
module env_scg_div64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quot
);

    logic [63:0] q_reg;
    logic [63:0] r_reg;
    logic [63:0] mb_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        busy_reg;
    logic        fix_reg;
    logic        done_reg;
    logic [64:0] rem_sh;
    logic [64:0] trial;

    assign rem_sh = {r_reg, q_reg[63]};
    assign trial  = rem_sh - {1'b0, mb_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end else if (fix_reg) begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[63] ^ divisor[63];
            q_reg   <= dividend[63] ? 64'd0 - dividend : dividend;
            mb_reg  <= divisor[63] ? 64'd0 - divisor : divisor;
            r_reg   <= 64'd0;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= rem_sh[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end else if (fix_reg) begin
            if (neg_reg) begin
                q_reg <= 64'd0 - q_reg;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
